// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never hold on a sampled clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/bvcc_pkg.sv =====
// Package of the binary vector constraint checker: field widths, codes and the
// command type passed from the front end to the back end. No dependencies.
package bvcc_pkg;

	localparam int REQ_W   = 2;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 5;
	localparam int COEF_W  = 32;
	localparam int SENSE_W = 2;
	localparam int BOUND_W = 32;
	localparam int VEC_W   = 32;
	localparam int SUM_W   = 40;
	localparam int VARS_W  = 6;
	localparam int ROWS_W  = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_COEF  = 2'd0,
		REQ_BOUND = 2'd1,
		REQ_TEST  = 2'd2
	} req_t;

	typedef enum logic [SENSE_W-1:0] {
		SENSE_LE = 2'd0,
		SENSE_GE = 2'd1,
		SENSE_EQ = 2'd2
	} sense_t;

	typedef enum logic {
		CFG_VARS = 1'b0,
		CFG_ROWS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		req_t                kind;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [COEF_W-1:0]   coef;
		logic [SENSE_W-1:0]  sense;
		logic [BOUND_W-1:0]  bound;
		logic [VEC_W-1:0]    vec;
	} cmd_t;

endpackage

// ===== rtl/core/bvcc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the coefficient columns and the sense/bound table. No dependencies.
module bvcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/bvcc_front.sv =====
// Front end of the checker: accepts transactions, drops loads that fall outside
// the table or carry an unused request code, and queues the rest. Uses bvcc_pkg.
`include "assert_macros.svh"

module bvcc_front import bvcc_pkg::*; #(
	parameter int MAX_VARS = 32,
	parameter int MAX_ROWS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	localparam int QDEPTH = 2;

	cmd_t       entry_q [0:QDEPTH-1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	logic       pop;

	always_comb begin
		unique case (in_cmd.kind)
			REQ_COEF:  keep = (int'(in_cmd.row) < MAX_ROWS) && (int'(in_cmd.col) < MAX_VARS);
			REQ_BOUND: keep = int'(in_cmd.row) < MAX_ROWS;
			REQ_TEST:  keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	assign in_ready  = cnt_q != 2'(QDEPTH);
	assign out_valid = cnt_q != 2'd0;
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready && keep;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > 2'(QDEPTH), "queue count overflow")
	`ASSERT_AT(a_queued_kind, clk, arst_n, out_valid |-> (out_cmd.kind == REQ_COEF || out_cmd.kind == REQ_BOUND || out_cmd.kind == REQ_TEST), "unused request reached the queue head")
	`ASSERT_AT(a_ptr_sync, clk, arst_n, (cnt_q == 2'd0 || cnt_q == 2'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

// ===== rtl/core/bvcc_back.sv =====
// Back end of the checker: executes table loads and runs test vectors through
// the row pipeline (RAM read, registered adder tree, compare). Uses bvcc_pkg,
// bvcc_ram and the assertion macros.
`include "assert_macros.svh"

module bvcc_back import bvcc_pkg::*; #(
	parameter int MAX_VARS = 32,
	parameter int MAX_ROWS = 64,
	localparam int VW = $clog2(MAX_VARS + 1),
	localparam int CW = $clog2(MAX_ROWS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cmd_t          cmd,
	input  logic [VW-1:0] ncols,
	input  logic [CW-1:0] nrows,
	output logic          res_valid,
	input  logic          res_ready,
	output logic          res_violated
);

	localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LV     = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 0;
	localparam int LEAVES = 1 << LV;
	localparam int SB_W   = SENSE_W + BOUND_W;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t                     state_q;
	logic [CW-1:0]              row_q;
	logic [CW-1:0]              nrows_q;
	logic [MAX_VARS-1:0]        mask_q;
	logic                       fail_q;
	logic                       res_valid_q;
	logic                       res_viol_q;

	logic                       rd_vld_s1;
	logic [COEF_W-1:0]          coef_rd [0:LEAVES-1];
	logic [SB_W-1:0]            sb_rd;
	logic signed [SUM_W-1:0]    sum_s2 [0:LV][0:LEAVES-1];
	logic [LV:0]                vld_s2;
	logic [SENSE_W-1:0]         sense_s2 [0:LV];
	logic [BOUND_W-1:0]         bound_s2 [0:LV];

	logic                       pop;
	logic                       issue;
	logic                       in_flight;
	logic                       res_load;
	logic                       coef_we;
	logic                       sb_we;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [MAX_VARS-1:0]        mask;
	logic [MAX_VARS+VEC_W-1:0]  vec_ext;
	logic [LEAVES-1:0]          mask_ext;
	logic signed [SUM_W-1:0]    sum_fin;
	logic signed [SUM_W-1:0]    bnd_fin;
	logic                       row_fail;

	assign cmd_ready    = state_q == ST_IDLE;
	assign pop          = cmd_valid && cmd_ready;
	assign coef_we      = pop && (cmd.kind == REQ_COEF);
	assign sb_we        = pop && (cmd.kind == REQ_BOUND);
	assign waddr        = AW'(cmd.row);
	assign raddr        = row_q[AW-1:0];
	assign issue        = (state_q == ST_RUN) && (row_q != nrows_q);
	assign in_flight    = rd_vld_s1 || (|vld_s2);
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign res_valid    = res_valid_q;
	assign res_violated = res_viol_q;

	assign vec_ext  = {{MAX_VARS{1'b0}}, cmd.vec};
	assign mask_ext = LEAVES'(mask_q);

	always_comb begin
		for (int j = 0; j < MAX_VARS; j++) begin
			mask[j] = vec_ext[j] && (j < int'(ncols));
		end
	end

	for (genvar j = 0; j < LEAVES; j++) begin : g_col
		if (j < MAX_VARS) begin : g_ram
			bvcc_ram #(
				.WIDTH(COEF_W),
				.DEPTH(MAX_ROWS)
			) u_coef (
				.clk   (clk),
				.we    (coef_we && (int'(cmd.col) == j)),
				.waddr (waddr),
				.wdata (cmd.coef),
				.re    (issue),
				.raddr (raddr),
				.rdata (coef_rd[j])
			);
		end else begin : g_pad
			assign coef_rd[j] = '0;
		end
	end

	bvcc_ram #(
		.WIDTH(SB_W),
		.DEPTH(MAX_ROWS)
	) u_sense_bound (
		.clk   (clk),
		.we    (sb_we),
		.waddr (waddr),
		.wdata ({cmd.sense, cmd.bound}),
		.re    (issue),
		.raddr (raddr),
		.rdata (sb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			vld_s2    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			vld_s2    <= (LV + 1)'({vld_s2, rd_vld_s1});
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LEAVES; i++) begin
			sum_s2[0][i] <= mask_ext[i] ?
				{{(SUM_W - COEF_W){coef_rd[i][COEF_W-1]}}, coef_rd[i]} : '0;
		end
		sense_s2[0] <= sb_rd[SB_W-1:BOUND_W];
		bound_s2[0] <= sb_rd[BOUND_W-1:0];
		for (int k = 0; k < LV; k++) begin
			for (int i = 0; i < (LEAVES >> (k + 1)); i++) begin
				sum_s2[k+1][i] <= sum_s2[k][2*i] + sum_s2[k][2*i+1];
			end
			sense_s2[k+1] <= sense_s2[k];
			bound_s2[k+1] <= bound_s2[k];
		end
	end

	assign sum_fin = sum_s2[LV][0];
	assign bnd_fin = {{(SUM_W - BOUND_W){bound_s2[LV][BOUND_W-1]}}, bound_s2[LV]};

	always_comb begin
		unique case (sense_s2[LV])
			SENSE_LE: row_fail = sum_fin > bnd_fin;
			SENSE_GE: row_fail = sum_fin < bnd_fin;
			SENSE_EQ: row_fail = sum_fin != bnd_fin;
			default:  row_fail = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			nrows_q     <= '0;
			mask_q      <= '0;
			fail_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_viol_q  <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_viol_q  <= fail_q;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (cmd.kind == REQ_TEST)) begin
						row_q   <= '0;
						nrows_q <= nrows;
						mask_q  <= mask;
						fail_q  <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (vld_s2[LV] && row_fail) begin
						fail_q <= 1'b1;
					end
					if (issue) begin
						row_q <= row_q + 1'b1;
					end else if (!in_flight) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_AT(a_idle_drained, clk, arst_n, (state_q == ST_IDLE) |-> !in_flight, "busy while idle")
	`ASSERT_AT(a_row_bound, clk, arst_n, (state_q == ST_RUN) |-> (row_q <= nrows_q), "row overrun")
	`ASSERT_AT(a_done_drained, clk, arst_n, (state_q == ST_DONE) |-> !in_flight, "early result")

endmodule

// ===== rtl/core/binary_vector_constraint_checker.sv =====
// Top level of the binary vector constraint checker: stream ports, configuration
// registers, front end queue and back end row pipeline. Uses bvcc_pkg, bvcc_front
// and bvcc_back.

// A load transaction (coefficient or sense and bound) does not take the back end
// out of its idle state. A test transaction occupies the back end until its result
// is loaded into the output register: for each constraint row in use, the back end
// reads that row of all coefficient columns, one row per cycle, masks it, sums it
// in a registered adder tree of log2(MAX_VARS) stages and compares it with the
// row bound. A two-entry queue lets the input side accept up to two transactions
// while a test runs or a result waits on the output register. Entries must be
// loaded before a test reads them; the tables are not cleared at reset.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module binary_vector_constraint_checker import bvcc_pkg::*; #(
	parameter int MAX_VARS = 32,
	parameter int MAX_ROWS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: row_index[5:0], column_index[4:0], coefficient[31:0],
	// sense[1:0], bound[31:0], vector_bits[31:0], then zero padding.
	input  logic [111:0] s_tdata,
	// Fields from bit 0: req_type[1:0].
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: violated, then zero padding.
	output logic [7:0]   m_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [6:0]   cfg_data
);

	localparam int VW = $clog2(MAX_VARS + 1);
	localparam int CW = $clog2(MAX_ROWS + 1);

	logic [VARS_W-1:0] vars_q;
	logic [ROWS_W-1:0] rows_q;
	logic [VW-1:0]     ncols;
	logic [CW-1:0]     nrows;
	cmd_t              in_cmd;
	cmd_t              q_cmd;
	logic              q_valid;
	logic              q_ready;
	logic              violated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= VARS_W'(32);
			rows_q <= ROWS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_VARS: vars_q <= cfg_data[VARS_W-1:0];
				CFG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ncols = (int'(vars_q) > MAX_VARS) ? VW'(MAX_VARS) : VW'(vars_q);
	assign nrows = (int'(rows_q) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(rows_q);

	assign in_cmd.kind  = req_t'(s_tuser);
	assign in_cmd.row   = s_tdata[5:0];
	assign in_cmd.col   = s_tdata[10:6];
	assign in_cmd.coef  = s_tdata[42:11];
	assign in_cmd.sense = s_tdata[44:43];
	assign in_cmd.bound = s_tdata[76:45];
	assign in_cmd.vec   = s_tdata[108:77];

	bvcc_front #(
		.MAX_VARS(MAX_VARS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	bvcc_back #(
		.MAX_VARS(MAX_VARS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd          (q_cmd),
		.ncols        (ncols),
		.nrows        (nrows),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_violated (violated)
	);

	assign m_tdata = {7'd0, violated};

endmodule

// ===== dv/tb_binary_vector_constraint_checker.sv =====
// Self-checking testbench for binary_vector_constraint_checker: loads constraint tables,
// streams test vectors and compares each verdict with an in-bench prediction.
// Depends on bvcc_pkg and the RTL of the checker only.
`timescale 1ns / 100ps

module tb_binary_vector_constraint_checker import bvcc_pkg::*;;

	localparam logic [1:0]  REQ_UNUSED = 2'd3;
	localparam logic [1:0]  SENSE_NONE = 2'd3;
	localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
	localparam int          TABLE_ROWS = 64;
	localparam int          TABLE_COLS = 32;
	localparam int          FILL_ROWS  = 4;

	typedef struct packed {
		logic [VEC_W-1:0]   vec;
		logic [BOUND_W-1:0] bound;
		logic [SENSE_W-1:0] sense;
		logic [COEF_W-1:0]  coef;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
	} item_fields_t;

	typedef struct packed {
		logic [1:0]   kind;
		item_fields_t f;
	} item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	logic         cfg_we = 1'b0;
	logic [0:0]   cfg_index = '0;
	logic [6:0]   cfg_data = '0;

	logic signed [31:0] coef_table [TABLE_ROWS][TABLE_COLS];
	logic signed [31:0] bound_table [TABLE_ROWS];
	logic [1:0]         sense_table [TABLE_ROWS];
	bit                 coef_written [TABLE_ROWS][TABLE_COLS];
	logic [5:0]         vars_count = 6'd32;
	logic [6:0]         rows_count = 7'd1;

	item_t pending[$];
	item_t offered;
	bit    violation_expected[$];
	int    pushed_count = 0;
	int    taken_count = 0;
	int    mismatches = 0;
	bit    steady = 1'b0;
	bit    hold_arm = 1'b0;
	bit    hold_done;
	int    hold_left;

	binary_vector_constraint_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit vector_violates(logic [31:0] vec);
		int     ncols;
		int     nrows;
		longint sum;
		longint b;
		bit     bad;
		ncols = (vars_count > TABLE_COLS) ? TABLE_COLS : int'(vars_count);
		nrows = (rows_count > TABLE_ROWS) ? TABLE_ROWS : int'(rows_count);
		bad = 1'b0;
		for (int r = 0; r < nrows; r++) begin
			sum = 0;
			for (int c = 0; c < ncols; c++)
				if (vec[c])
					sum += longint'(coef_table[r][c]);
			b = longint'(bound_table[r]);
			if ((sense_table[r] == SENSE_LE || sense_table[r] == SENSE_EQ) && sum > b)
				bad = 1'b1;
			if ((sense_table[r] == SENSE_GE || sense_table[r] == SENSE_EQ) && sum < b)
				bad = 1'b1;
		end
		return bad;
	endfunction

	task automatic absorb_request(item_t it);
		case (it.kind)
			REQ_COEF: begin
				coef_table[it.f.row][it.f.col] = it.f.coef;
			end
			REQ_BOUND: begin
				sense_table[it.f.row] = it.f.sense;
				bound_table[it.f.row] = it.f.bound;
			end
			REQ_TEST: begin
				violation_expected.push_back(vector_violates(it.f.vec));
			end
			default: begin
			end
		endcase
	endtask

	task automatic note_mismatch(string what, logic want, logic got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s, expected violated=%b, got violated=%b", $realtime, what, want, got);
	endtask

	// Sender: a new transaction is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_request(offered);
				taken_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
					offered = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, offered.f};
					s_tuser <= offered.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed once so that the input queue backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (violation_expected.size() == 0)
					note_mismatch("result with no transaction pending", 1'bx, m_tdata[0]);
				else if (violation_expected[0] !== m_tdata[0])
					note_mismatch("verdict differs", violation_expected.pop_front(),
						m_tdata[0]);
				else
					void'(violation_expected.pop_front());
			end
			m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 37);
		end
	end

	function automatic item_t make_item(logic [1:0] kind);
		item_t it;
		it.kind = kind;
		it.f = item_fields_t'({$urandom, $urandom, $urandom, $urandom});
		return it;
	endfunction

	task automatic queue_item(item_t it);
		pending.push_back(it);
		pushed_count++;
	endtask

	task automatic push_coef(int row, int col, logic [31:0] value);
		item_t it;
		it = make_item(REQ_COEF);
		it.f.row = ROW_W'(row);
		it.f.col = COL_W'(col);
		it.f.coef = value;
		coef_written[row][col] = 1'b1;
		queue_item(it);
	endtask

	task automatic push_bound(int row, logic [1:0] sense, logic [31:0] value);
		item_t it;
		it = make_item(REQ_BOUND);
		it.f.row = ROW_W'(row);
		it.f.sense = sense;
		it.f.bound = value;
		queue_item(it);
	endtask

	// A vector bit inside the active columns stays set only where every active
	// row already holds a coefficient for that column.
	task automatic push_test(logic [31:0] vec);
		item_t it;
		int    ncols;
		int    nrows;
		ncols = (vars_count > TABLE_COLS) ? TABLE_COLS : int'(vars_count);
		nrows = (rows_count > TABLE_ROWS) ? TABLE_ROWS : int'(rows_count);
		for (int c = 0; c < ncols; c++)
			for (int r = 0; r < nrows; r++)
				if (!coef_written[r][c])
					vec[c] = 1'b0;
		it = make_item(REQ_TEST);
		it.f.vec = vec;
		queue_item(it);
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return $urandom;
			default: return 32'(int'($urandom_range(8)) - 4);
		endcase
	endfunction

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return $urandom;
			default: return 32'(int'($urandom_range(12)) - 6);
		endcase
	endfunction

	function automatic logic [31:0] pick_vector();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			2: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Waits until every transaction is taken and answered, then lets loads drain.
	task automatic settle();
		while (taken_count != pushed_count || violation_expected.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VARS)
			vars_count = value[5:0];
		else
			rows_count = value;
		@(posedge clk);
	endtask

	task automatic set_counts(logic [5:0] vars, logic [6:0] rows);
		write_register(CFG_VARS, {1'b0, vars});
		write_register(CFG_ROWS, rows);
	endtask

	initial begin
		int          random_items;
		int          phase;
		int          count;
		int          pick;
		int          active_rows;
		int          active_cols;
		int          row;
		int          col;
		logic [5:0]  vars;
		logic [6:0]  rows;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every bound is written up front, and the coefficients of the first rows.
		for (int r = 0; r < TABLE_ROWS; r++) begin
			push_bound(r, (r == 0) ? SENSE_LE : 2'($urandom_range(3)), pick_bound());
			if (r < FILL_ROWS)
				for (int c = 0; c < TABLE_COLS; c++)
					push_coef(r, c, (r == 0) ? WORD_MAX : (r == 1) ? WORD_MIN : pick_coef());
		end
		settle();

		// Reset counts: one row, all columns; row 0 holds the largest coefficients.
		push_bound(0, SENSE_LE, WORD_MAX);
		push_test('1);
		push_test('0);
		push_test(32'h0000_0001);
		push_bound(0, SENSE_GE, WORD_MAX);
		push_test(32'h8000_0000);
		push_test('0);
		push_bound(0, SENSE_EQ, WORD_MAX);
		push_test(32'h0000_0020);
		push_test(32'h0000_0060);
		push_test('0);
		push_bound(0, SENSE_NONE, WORD_MIN);
		push_test('1);
		queue_item(make_item(REQ_UNUSED));
		settle();

		// Row 1 holds the most negative coefficients.
		set_counts(6'd32, 7'd2);
		push_bound(0, SENSE_NONE, '0);
		push_bound(1, SENSE_GE, WORD_MIN);
		push_test('1);
		push_test(32'h0000_0008);
		push_bound(1, SENSE_LE, WORD_MIN);
		push_test('0);
		push_bound(1, SENSE_EQ, WORD_MIN);
		push_test(32'h0000_0008);
		settle();

		// Count extremes: no columns, saturated columns and rows, no rows.
		set_counts(6'd0, 7'd64);
		repeat (4) push_test(pick_vector());
		settle();
		set_counts(6'd63, 7'd127);
		repeat (4) push_test(pick_vector());
		settle();
		set_counts(6'd1, 7'd0);
		repeat (4) push_test(pick_vector());
		settle();

		random_items = 0;
		phase = 0;
		while (random_items < 220) begin
			case ($urandom_range(7))
				0: rows = 7'd0;
				1: rows = 7'd64;
				2: rows = 7'd127;
				3: rows = 7'($urandom_range(63, 5));
				default: rows = 7'($urandom_range(4, 1));
			endcase
			case ($urandom_range(7))
				0: vars = 6'd0;
				1: vars = 6'd63;
				2: vars = 6'd1;
				3: vars = 6'd32;
				default: vars = 6'($urandom_range(31, 1));
			endcase
			set_counts(vars, rows);
			active_rows = (rows_count > TABLE_ROWS) ? TABLE_ROWS : int'(rows_count);
			active_cols = (vars_count > TABLE_COLS) ? TABLE_COLS : int'(vars_count);
			count = (phase == 1 || phase == 2) ? 60 : int'($urandom_range(50, 20));
			if (phase == 1)
				hold_arm <= 1'b1;
			if (phase == 2)
				steady <= 1'b1;
			for (int k = 0; k < count; k++) begin
				pick = $urandom_range(99);
				row = (active_rows != 0 && $urandom_range(3) != 0) ?
					$urandom_range(active_rows - 1) : $urandom_range(TABLE_ROWS - 1);
				col = (active_cols != 0 && $urandom_range(3) != 0) ?
					$urandom_range(active_cols - 1) : $urandom_range(TABLE_COLS - 1);
				if (pick < 40) begin
					push_coef(row, col, pick_coef());
				end else if (pick < 55) begin
					push_bound(row, 2'($urandom_range(3)), pick_bound());
				end else if (pick < 95) begin
					push_test(pick_vector());
				end else begin
					queue_item(make_item(REQ_UNUSED));
					random_items--;
				end
				random_items++;
			end
			settle();
			steady <= 1'b0;
			phase++;
		end

		if (mismatches == 0 && violation_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
